[hdl/sudf_pkg.sv]
// Shared types, constants and the CRC-8 helper of the datagram framer.
package sudf_pkg;

  localparam logic [7:0] MAX_NODE_ADDRESS = 8'd3;
  localparam logic [7:0] SYNC_BYTE        = 8'h05;
  localparam logic [7:0] CRC_POLY         = 8'h07;
  localparam logic [7:0] WRITE_FLAG       = 8'h80;
  localparam logic [7:0] READ_MASK        = 8'h7F;
  localparam logic [7:0] MASTER_ADDR      = 8'hFF;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RX      = 2'd2;
  localparam logic [1:0] OP_TIMEOUT = 2'd3;

  localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
  localparam logic [2:0] READ_LAST_IDX  = 3'd3;
  localparam logic [2:0] RESULT_LAST_IDX = 3'd0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  node_address;
    logic [7:0]  reg_num;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] read_value;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_READ,
    JOB_RESULT
  } job_kind_t;

  // One unit of work handed from the front end to the emitter.
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  node;
    logic [7:0]  reg_byte;
    logic [31:0] value;
  } job_t;

  // CRC-8, poly 0x07, message bits taken LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      fb = c[7] ^ data[b];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

[hdl/sudf_front.sv]
// Front end: accepts items, tracks the reply, and queues emit jobs.
module sudf_front
  import sudf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic        pending_r, pending_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [31:0] word_r, word_nxt;
  logic        accept;
  logic [7:0]  node_clamped;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign node_clamped = (in_data.node_address > MAX_NODE_ADDRESS) ?
                        MAX_NODE_ADDRESS : in_data.node_address;

  always_comb begin
    pending_nxt  = pending_r;
    count_nxt    = count_r;
    hdr_good_nxt = hdr_good_r;
    word_nxt     = word_r;
    q_push       = 1'b0;
    q_job.kind     = JOB_RESULT;
    q_job.node     = node_clamped;
    q_job.reg_byte = in_data.reg_num | WRITE_FLAG;
    q_job.value    = in_data.write_value;
    if (accept) begin
      case (in_data.opcode)
        OP_WRITE: begin
          pending_nxt  = 1'b0;
          count_nxt    = 3'd0;
          hdr_good_nxt = 1'b0;
          word_nxt     = 32'd0;
          q_push       = 1'b1;
          q_job.kind   = JOB_WRITE;
        end
        OP_READ: begin
          pending_nxt    = 1'b1;
          count_nxt      = 3'd0;
          hdr_good_nxt   = 1'b0;
          word_nxt       = 32'd0;
          q_push         = 1'b1;
          q_job.kind     = JOB_READ;
          q_job.reg_byte = in_data.reg_num & READ_MASK;
        end
        OP_RX: begin
          if (pending_r) begin
            count_nxt = count_r + 3'd1;
            case (count_r)
              3'd0: hdr_good_nxt = (in_data.rx_byte == SYNC_BYTE);
              3'd1: hdr_good_nxt = hdr_good_r && (in_data.rx_byte == MASTER_ADDR);
              3'd3, 3'd4, 3'd5, 3'd6: word_nxt = {word_r[23:0], in_data.rx_byte};
              3'd7: begin
                q_push       = 1'b1;
                q_job.kind   = JOB_RESULT;
                q_job.value  = hdr_good_r ? word_r : 32'd0;
                pending_nxt  = 1'b0;
                count_nxt    = 3'd0;
                hdr_good_nxt = 1'b0;
                word_nxt     = 32'd0;
              end
              default: ;
            endcase
          end
        end
        OP_TIMEOUT: begin
          if (pending_r) begin
            q_push       = 1'b1;
            q_job.kind   = JOB_RESULT;
            q_job.value  = 32'd0;
            pending_nxt  = 1'b0;
            count_nxt    = 3'd0;
            hdr_good_nxt = 1'b0;
            word_nxt     = 32'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      count_r    <= 3'd0;
      hdr_good_r <= 1'b0;
      word_r     <= 32'd0;
    end else begin
      pending_r  <= pending_nxt;
      count_r    <= count_nxt;
      hdr_good_r <= hdr_good_nxt;
      word_r     <= word_nxt;
    end
  end

endmodule

[hdl/sudf_queue.sv]
// Two-entry job queue between the front end and the emitter.
module sudf_queue
  import sudf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  job_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hdl/sudf_back.sv]
// Emitter: serializes queued jobs into bytes with a running CRC-8.
module sudf_back
  import sudf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [2:0] idx_r, idx_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       load;
  logic       is_last;
  logic [2:0] last_idx;
  logic [7:0] cur_byte;
  logic       is_result;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_result = (q_job.kind == JOB_RESULT);

  always_comb begin
    case (q_job.kind)
      JOB_WRITE: last_idx = WRITE_LAST_IDX;
      JOB_READ:  last_idx = READ_LAST_IDX;
      default:   last_idx = RESULT_LAST_IDX;
    endcase
  end

  always_comb begin
    case (idx_r)
      3'd0:    cur_byte = SYNC_BYTE;
      3'd1:    cur_byte = q_job.node;
      3'd2:    cur_byte = q_job.reg_byte;
      3'd3:    cur_byte = (q_job.kind == JOB_WRITE) ? q_job.value[31:24] : crc_r;
      3'd4:    cur_byte = q_job.value[23:16];
      3'd5:    cur_byte = q_job.value[15:8];
      3'd6:    cur_byte = q_job.value[7:0];
      3'd7:    cur_byte = crc_r;
      default: cur_byte = crc_r;
    endcase
  end

  assign load    = q_valid && (!out_valid_r || out_ready);
  assign is_last = (idx_r == last_idx);
  assign q_pop   = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.result_kind = is_result;
      out_data_nxt.tx_byte     = is_result ? 8'd0 : cur_byte;
      out_data_nxt.last        = is_last;
      out_data_nxt.read_value  = is_result ? q_job.value : 32'd0;
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
      crc_nxt = is_last ? 8'd0 : crc8_byte(crc_r, cur_byte);
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      crc_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/stepper_uart_datagram_framer_core.sv]
// With queue and emitter idle, a request's job enters the queue at its transaction, and its
//   first byte then goes from the queue head into the registered output on out_data.
// Throughput: one byte per cycle while out_ready allows; a write is 8 bytes, a read request 4,
//   a read result one item; the two-entry job queue sets how far input runs ahead.
// Items that cause no result only need a free queue slot.
// Reset: rst_n synchronous, active low; clears reply tracking, queue and output valid.
module stepper_uart_datagram_framer_core
  import sudf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Front end -> queue
  logic q_push;
  job_t q_push_job;
  logic q_full;
  // Queue -> emitter
  logic q_head_valid;
  job_t q_head_job;
  logic q_pop;

  // Front end: reply tracking happens at the input transaction, so a new
  // request drops a pending reply immediately.
  sudf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  sudf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop)
  );

  // Emitter: CRC accumulates byte by byte as the datagram goes out.
  sudf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_head_valid),
    .q_job     (q_head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind |-> out_data.last && out_data.tx_byte == 8'd0)
    else $error("read result without last or with nonzero tx byte");

  a_tx_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.result_kind |-> out_data.read_value == 32'd0)
    else $error("transmit byte carries a read value");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || q_pop)
    else $error("job queue overflow");

  a_after_last_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last ##1 out_valid && !out_data.result_kind
      |-> out_data.tx_byte == SYNC_BYTE)
    else $error("datagram does not start with sync");
`endif

endmodule
